[sv/biou_pkg.sv]
// Package with the shared widths, types and constants of the box overlap ratio block.
`timescale 1ns / 1ps

package biou_pkg;

    // Coordinates are signed fixed point; box edges differ by up to 17 bits.
    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    // A box area is the product of its width and its height.
    localparam int AREA_W  = 2 * DIFF_W;
    // A non-empty overlap has edges of at most 16 unsigned bits.
    localparam int INTER_W = 2 * COORD_W;
    // Sum of two areas minus the overlap, signed, with headroom.
    localparam int SUM_W   = AREA_W + 2;
    // A positive union is at most twice the largest box area.
    localparam int UNI_W   = INTER_W + 1;

    localparam int RATIO_FRAC_BITS_DEF = 16;

    // Threshold register.
    localparam int              MUA_W     = 8;
    localparam logic [MUA_W-1:0] MUA_RESET = 8'd3;

    // Register port geometry. Bit 2 of the byte address selects the register word.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_MIN_UNION_AREA = 1'b0;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;

    // Control that travels with each item down the divider row.
    typedef struct packed {
        logic valid;
        logic zero;
        logic sat;
    } biou_ctl_t;

    // Divider operands that travel with each item.
    typedef struct packed {
        logic [UNI_W-1:0] rem;
        logic [UNI_W-1:0] uni;
    } biou_div_t;

endpackage

[sv/biou_if.sv]
// Channel interfaces for box pairs coming in and overlap ratios going out.
`timescale 1ns / 1ps

interface biou_box_if
    import biou_pkg::*;
();
    logic   valid;
    logic   ready;
    coord_t a_x_min;
    coord_t a_y_min;
    coord_t a_x_max;
    coord_t a_y_max;
    coord_t b_x_min;
    coord_t b_y_min;
    coord_t b_x_max;
    coord_t b_y_max;

    modport source (
        output valid, a_x_min, a_y_min, a_x_max, a_y_max,
        output b_x_min, b_y_min, b_x_max, b_y_max,
        input  ready
    );
    modport sink (
        input  valid, a_x_min, a_y_min, a_x_max, a_y_max,
        input  b_x_min, b_y_min, b_x_max, b_y_max,
        output ready
    );
endinterface

interface biou_ratio_if
    import biou_pkg::*;
#(
    parameter int RATIO_W = RATIO_FRAC_BITS_DEF + 1
) ();
    logic               valid;
    logic               ready;
    logic [RATIO_W-1:0] overlap_ratio;

    modport source (output valid, overlap_ratio, input ready);
    modport sink (input valid, overlap_ratio, output ready);
endinterface

[sv/box_iou.sv]
// Top level of the box overlap ratio block: register port, front pipeline, divider row, output.
`timescale 1ns / 1ps

// The block takes one pair of axis-aligned boxes per item, each given by min and max
// corners in signed Q12.4, and returns their intersection over union as unsigned
// Q1.16 (RATIO_FRAC_BITS fractional bits, 1.0 is one followed by zeros), truncated
// and saturated to 1.0. A union that is not positive, or below the min_union_area
// register (Q.8 area units, reset value 3), gives 0. Inverted boxes keep their signed
// area, so they can shrink the union. A new item is taken in every cycle unless a
// stalled output has backed up to the input; each item passes through three front
// stages (edge differences, the 17 by 17 area products, the union sum and threshold
// test), then a row of RATIO_FRAC_BITS divider cells, each of which settles one
// quotient bit with a 34-bit compare and subtract, and then the output register.
// Every stage holds its item while the next one is full, so a stalled output fills
// the empty stages behind it before the input side stops. The register must be
// written only while no item is in flight.

module box_iou
    import biou_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    biou_box_if.sink              box_in,
    biou_ratio_if.source          ratio_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int RATIO_W = RATIO_FRAC_BITS + 1;

    // Threshold register, written through the register port.
    logic [MUA_W-1:0] mua_reg;
    logic             mua_wr;

    assign pready = 1'b1;
    // Bit 2 of the byte address picks the register word; other words read as zero.
    assign mua_wr = psel && penable && pwrite && (paddr[2] == REG_MIN_UNION_AREA);
    assign prdata = (paddr[2] == REG_MIN_UNION_AREA)
                  ? {{(APB_DATA_W-MUA_W){1'b0}}, mua_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mua_reg <= MUA_RESET;
        end
        else if (mua_wr)
        begin
            mua_reg <= pwdata[MUA_W-1:0];
        end
    end

    // Links between the front pipeline, the divider cells and the output stage.
    // Link k feeds cell k; link RATIO_FRAC_BITS feeds the output register.
    biou_ctl_t                  ctl_w [0:RATIO_FRAC_BITS];
    biou_div_t                  div_w [0:RATIO_FRAC_BITS];
    logic [RATIO_FRAC_BITS-1:0] q_w   [0:RATIO_FRAC_BITS];
    logic                       rdy_w [0:RATIO_FRAC_BITS];

    biou_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .box_in         (box_in),
        .min_union_area (mua_reg),
        .dn_ctl         (ctl_w[0]),
        .dn_div         (div_w[0]),
        .dn_ready       (rdy_w[0])
    );

    assign q_w[0] = '0;

    // Each cell shifts in one quotient bit, most significant first.
    for (genvar k = 0; k < RATIO_FRAC_BITS; k++)
    begin : g_cell
        biou_cell #(
            .Q_W (RATIO_FRAC_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_ctl   (ctl_w[k]),
            .up_div   (div_w[k]),
            .up_q     (q_w[k]),
            .up_ready (rdy_w[k]),
            .dn_ctl   (ctl_w[k+1]),
            .dn_div   (div_w[k+1]),
            .dn_q     (q_w[k+1]),
            .dn_ready (rdy_w[k+1])
        );
    end

    // Output register: parts the divider row from the consumer.
    logic               out_valid_reg;
    logic [RATIO_W-1:0] ratio_reg, ratio_next;

    assign rdy_w[RATIO_FRAC_BITS] = !out_valid_reg || ratio_out.ready;

    always_comb
    begin
        if (ctl_w[RATIO_FRAC_BITS].zero)
        begin
            ratio_next = '0;
        end
        else if (ctl_w[RATIO_FRAC_BITS].sat)
        begin
            ratio_next = {1'b1, {RATIO_FRAC_BITS{1'b0}}};
        end
        else
        begin
            ratio_next = {1'b0, q_w[RATIO_FRAC_BITS]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rdy_w[RATIO_FRAC_BITS])
        begin
            out_valid_reg <= ctl_w[RATIO_FRAC_BITS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_w[RATIO_FRAC_BITS])
        begin
            ratio_reg <= ratio_next;
        end
    end

    assign ratio_out.valid         = out_valid_reg;
    assign ratio_out.overlap_ratio = ratio_reg;

endmodule

[sv/biou_front.sv]
// Front pipeline: edge differences, areas, union and divider setup in three stages.
`timescale 1ns / 1ps

module biou_front
    import biou_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    biou_box_if.sink         box_in,
    input  logic [MUA_W-1:0] min_union_area,
    output biou_ctl_t        dn_ctl,
    output biou_div_t        dn_div,
    input  logic             dn_ready
);

    logic adv1;
    logic adv2;
    logic adv3;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;

    // Stage 1 results.
    diff_t iw_reg, iw_next;
    diff_t ih_reg, ih_next;
    diff_t wa_reg, wa_next;
    diff_t ha_reg, ha_next;
    diff_t wb_reg, wb_next;
    diff_t hb_reg, hb_next;

    // Stage 2 results.
    logic [INTER_W-1:0]      inter_reg, inter_next;
    logic signed [AREA_W-1:0] area_a_reg, area_a_next;
    logic signed [AREA_W-1:0] area_b_reg, area_b_next;

    // Stage 3 results.
    biou_ctl_t ctl_reg, ctl_next;
    biou_div_t div_reg, div_next;

    coord_t x_lo, x_hi, y_lo, y_hi;
    logic signed [SUM_W-1:0] uni_s;
    logic [SUM_W-1:0]        inter_s;
    logic                    uni_pos;
    logic                    uni_ok;
    logic                    sat;

    assign adv3         = !v3_reg || dn_ready;
    assign adv2         = !v2_reg || adv3;
    assign adv1         = !v1_reg || adv2;
    assign box_in.ready = adv1;

    always_comb
    begin
        x_lo = (box_in.a_x_min > box_in.b_x_min) ? box_in.a_x_min : box_in.b_x_min;
        y_lo = (box_in.a_y_min > box_in.b_y_min) ? box_in.a_y_min : box_in.b_y_min;
        x_hi = (box_in.a_x_max < box_in.b_x_max) ? box_in.a_x_max : box_in.b_x_max;
        y_hi = (box_in.a_y_max < box_in.b_y_max) ? box_in.a_y_max : box_in.b_y_max;

        iw_next = DIFF_W'(x_hi) - DIFF_W'(x_lo);
        ih_next = DIFF_W'(y_hi) - DIFF_W'(y_lo);
        wa_next = DIFF_W'(box_in.a_x_max) - DIFF_W'(box_in.a_x_min);
        ha_next = DIFF_W'(box_in.a_y_max) - DIFF_W'(box_in.a_y_min);
        wb_next = DIFF_W'(box_in.b_x_max) - DIFF_W'(box_in.b_x_min);
        hb_next = DIFF_W'(box_in.b_y_max) - DIFF_W'(box_in.b_y_min);
    end

    always_comb
    begin
        // The overlap counts only when it is strictly positive on both axes.
        if (!iw_reg[DIFF_W-1] && (iw_reg != '0) && !ih_reg[DIFF_W-1] && (ih_reg != '0))
        begin
            inter_next = iw_reg[COORD_W-1:0] * ih_reg[COORD_W-1:0];
        end
        else
        begin
            inter_next = '0;
        end
        area_a_next = wa_reg * ha_reg;
        area_b_next = wb_reg * hb_reg;
    end

    always_comb
    begin
        inter_s = {{(SUM_W-INTER_W){1'b0}}, inter_reg};
        uni_s   = $signed({{(SUM_W-AREA_W){area_a_reg[AREA_W-1]}}, area_a_reg})
                + $signed({{(SUM_W-AREA_W){area_b_reg[AREA_W-1]}}, area_b_reg})
                - $signed(inter_s);
        uni_pos = !uni_s[SUM_W-1] && (uni_s != '0);
        // With the union known positive, the low bits compare as unsigned.
        uni_ok  = uni_pos && (uni_s[SUM_W-2:0] >= (SUM_W-1)'(min_union_area));
        // An overlap at or above the union comes from identical or inverted boxes.
        sat     = uni_ok && (inter_s >= $unsigned(uni_s));

        ctl_next.valid = v2_reg;
        ctl_next.zero  = !uni_ok;
        ctl_next.sat   = sat;
        div_next.uni   = uni_s[UNI_W-1:0];
        div_next.rem   = (uni_ok && !sat) ? {1'b0, inter_reg} : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= box_in.valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            iw_reg <= iw_next;
            ih_reg <= ih_next;
            wa_reg <= wa_next;
            ha_reg <= ha_next;
            wb_reg <= wb_next;
            hb_reg <= hb_next;
        end
        if (adv2)
        begin
            inter_reg  <= inter_next;
            area_a_reg <= area_a_next;
            area_b_reg <= area_b_next;
        end
        if (adv3)
        begin
            ctl_reg <= ctl_next;
            div_reg <= div_next;
        end
    end

    always_comb
    begin
        dn_ctl       = ctl_reg;
        dn_ctl.valid = v3_reg;
        dn_div       = div_reg;
    end

endmodule

[sv/biou_cell.sv]
// One divider cell: produces one quotient bit by a compare and subtract.
`timescale 1ns / 1ps

module biou_cell
    import biou_pkg::*;
#(
    parameter int Q_W = RATIO_FRAC_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  biou_ctl_t      up_ctl,
    input  biou_div_t      up_div,
    input  logic [Q_W-1:0] up_q,
    output logic           up_ready,
    output biou_ctl_t      dn_ctl,
    output biou_div_t      dn_div,
    output logic [Q_W-1:0] dn_q,
    input  logic           dn_ready
);

    logic            valid_reg;
    biou_ctl_t       ctl_reg, ctl_next;
    biou_div_t       div_reg, div_next;
    logic [Q_W-1:0]  q_reg, q_next;
    logic [UNI_W:0]  rem2;
    logic            ge;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        // The remainder stays below the union, so the shifted value fits one extra bit.
        rem2          = {up_div.rem, 1'b0};
        ge            = rem2 >= {1'b0, up_div.uni};
        ctl_next      = up_ctl;
        div_next.uni  = up_div.uni;
        div_next.rem  = ge ? UNI_W'(rem2 - {1'b0, up_div.uni}) : rem2[UNI_W-1:0];
        q_next        = {up_q[Q_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            ctl_reg <= ctl_next;
            div_reg <= div_next;
            q_reg   <= q_next;
        end
    end

    always_comb
    begin
        dn_ctl       = ctl_reg;
        dn_ctl.valid = valid_reg;
        dn_div       = div_reg;
        dn_q         = q_reg;
    end

endmodule

[tb/sv/box_iou_tb.sv]
// Testbench for the box overlap ratio block: directed and random box pairs checked against a predictor.
`timescale 1ns / 1ps

module box_iou_tb;
    import biou_pkg::*;

    localparam int RATIO_FRAC = RATIO_FRAC_BITS_DEF;
    localparam int RATIO_W    = RATIO_FRAC + 1;
    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << RATIO_FRAC;

    // Drain margin used by wait_for_results, in clock cycles.
    localparam int LATENCY = RATIO_FRAC + 3;

    localparam int     CLK_PERIOD   = 10;
    localparam int     RESET_CYCLES = 12;
    localparam int     DRAIN_CYCLES = 20000;
    localparam longint LIMIT_CYCLES = 1_500_000;

    localparam int RANDOM_PHASES     = 4;
    localparam int ITEMS_PER_PHASE   = 410;
    localparam int ITEMS_PER_SETTING = 60;

    // The threshold register sits at word 0; the other word of the port decodes to nothing.
    localparam logic [APB_ADDR_W-1:0] ADDR_MIN_UNION_AREA = {REG_MIN_UNION_AREA, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED         = {~REG_MIN_UNION_AREA, 2'b00};

    typedef struct packed {
        coord_t a_x_min, a_y_min, a_x_max, a_y_max;
        coord_t b_x_min, b_y_min, b_x_max, b_y_max;
    } box_pair_t;

    typedef struct {
        int unsigned        item_no;
        logic [RATIO_W-1:0] ratio;
    } ratio_expect_t;

    logic clk;
    logic rst_n;

    biou_box_if                         box_if ();
    biou_ratio_if #(.RATIO_W(RATIO_W))  ratio_if ();

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Copy of the threshold register as the block should hold it.
    logic [MUA_W-1:0] min_union_area_model;

    // Overlap ratios still owed by the block, oldest first.
    ratio_expect_t pending_ratios[$];
    ratio_expect_t oldest_ratio;

    int unsigned items_sent;
    int          error_count;

    // Switches for the random idle cycles on the box side and stalls on the ratio side.
    bit src_gap_en;
    bit sink_stall_en;

    box_iou #(
        .RATIO_FRAC_BITS(RATIO_FRAC)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .box_in   (box_if),
        .ratio_out(ratio_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin : watchdog
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Intersection over union of one box pair under a given threshold. Inverted boxes keep
    // their signed area, so the union can be small, zero or negative; a union that is not
    // positive gives 0 whatever the threshold is, which also keeps the divide safe.
    function automatic logic [RATIO_W-1:0] predict_overlap_ratio(input box_pair_t p,
                                                                 input logic [MUA_W-1:0] thr);
        longint          ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        longint          iw, ih, inter, area_a, area_b, uni;
        longint unsigned quo;
        ax0 = signed'(p.a_x_min);
        ay0 = signed'(p.a_y_min);
        ax1 = signed'(p.a_x_max);
        ay1 = signed'(p.a_y_max);
        bx0 = signed'(p.b_x_min);
        by0 = signed'(p.b_y_min);
        bx1 = signed'(p.b_x_max);
        by1 = signed'(p.b_y_max);
        iw = ((ax1 < bx1) ? ax1 : bx1) - ((ax0 > bx0) ? ax0 : bx0);
        ih = ((ay1 < by1) ? ay1 : by1) - ((ay0 > by0) ? ay0 : by0);
        // An overlap counts only when it is strictly positive on both axes.
        inter  = (iw > 0 && ih > 0) ? iw * ih : 0;
        area_a = (ax1 - ax0) * (ay1 - ay0);
        area_b = (bx1 - bx0) * (by1 - by0);
        uni    = area_a + area_b - inter;
        if (uni <= 0 || uni < longint'(thr))
            return '0;
        if (inter >= uni)
            return RATIO_ONE;
        quo = longint'(unsigned'(inter) << RATIO_FRAC) / longint'(unsigned'(uni));
        if (quo > longint'(RATIO_ONE))
            return RATIO_ONE;
        return RATIO_W'(quo);
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Idle run length: mostly none or short, now and then long.
    function automatic int idle_length();
        int r;
        r = rand_between(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return rand_between(1, 3);
        if (r < 97)
            return rand_between(4, 12);
        return rand_between(20, 60);
    endfunction

    // Keeps a box of the given span inside the signed 16-bit coordinate range.
    function automatic int clamp_low_edge(input int v, input int span);
        if (v < -32768)
            return -32768;
        if (v > 32767 - span)
            return 32767 - span;
        return v;
    endfunction

    // Low edge for a box of span bw that overlaps or touches [a0, a0 + aw].
    function automatic int place_overlapping(input int a0, input int aw, input int bw);
        return clamp_low_edge(a0 - bw + rand_between(0, aw + bw), bw);
    endfunction

    function automatic box_pair_t pair_of(input int ax0, input int ay0, input int ax1,
                                          input int ay1, input int bx0, input int by0,
                                          input int bx1, input int by1);
        box_pair_t p;
        p.a_x_min = coord_t'(ax0);
        p.a_y_min = coord_t'(ay0);
        p.a_x_max = coord_t'(ax1);
        p.a_y_max = coord_t'(ay1);
        p.b_x_min = coord_t'(bx0);
        p.b_y_min = coord_t'(by0);
        p.b_x_max = coord_t'(bx1);
        p.b_y_max = coord_t'(by1);
        return p;
    endfunction

    // Tiny boxes whose union lands around the threshold range, some of them inverted or flat.
    function automatic box_pair_t small_box_pair();
        int x0, y0, bx0, by0;
        x0  = rand_between(-20, 20);
        y0  = rand_between(-20, 20);
        bx0 = x0 + rand_between(-8, 8);
        by0 = y0 + rand_between(-8, 8);
        return pair_of(x0, y0, x0 + rand_between(-2, 22), y0 + rand_between(-2, 22),
                       bx0, by0, bx0 + rand_between(-2, 22), by0 + rand_between(-2, 22));
    endfunction

    // Mostly well-formed pairs that overlap, nest or just miss each other, at sizes from a
    // few pixels to the whole range; the rest are inverted boxes and raw noise.
    function automatic box_pair_t random_box_pair();
        int        kind, scale, ax0, ay0, aw, ah, bx0, by0, bw, bh;
        box_pair_t p;
        p    = box_pair_t'({$urandom, $urandom, $urandom, $urandom});
        kind = rand_between(0, 99);
        if (kind >= 85)
            return p;
        case (rand_between(0, 3))
            0:       scale = 16;
            1:       scale = 256;
            2:       scale = 4096;
            default: scale = 65535;
        endcase
        if (kind >= 70 && kind < 80)
            scale = 20;
        aw  = rand_between(0, scale);
        ah  = rand_between(0, scale);
        ax0 = clamp_low_edge(rand_between(-32768, 32767), aw);
        ay0 = clamp_low_edge(rand_between(-32768, 32767), ah);
        bw  = rand_between(0, scale);
        bh  = rand_between(0, scale);
        if (kind >= 45 && kind < 60)
        begin
            // Second box inside the first; the low part of the range makes them identical.
            bw  = rand_between(0, aw);
            bh  = rand_between(0, ah);
            bx0 = ax0 + rand_between(0, aw - bw);
            by0 = ay0 + rand_between(0, ah - bh);
            if (kind < 50)
            begin
                bw  = aw;
                bh  = ah;
                bx0 = ax0;
                by0 = ay0;
            end
        end
        else if (kind >= 60 && kind < 70)
        begin
            // To the right of the first box, touching it or a little apart.
            bx0 = clamp_low_edge(ax0 + aw + rand_between(0, 2), bw);
            by0 = place_overlapping(ay0, ah, bh);
        end
        else
        begin
            bx0 = place_overlapping(ax0, aw, bw);
            by0 = place_overlapping(ay0, ah, bh);
        end
        p = pair_of(ax0, ay0, ax0 + aw, ay0 + ah, bx0, by0, bx0 + bw, by0 + bh);
        if (kind >= 80)
        begin
            case (rand_between(0, 3))
                0:       {p.a_x_min, p.a_x_max} = {p.a_x_max, p.a_x_min};
                1:       {p.a_y_min, p.a_y_max} = {p.a_y_max, p.a_y_min};
                2:       {p.b_x_min, p.b_x_max} = {p.b_x_max, p.b_x_min};
                default: {p.b_y_min, p.b_y_max} = {p.b_y_max, p.b_y_min};
            endcase
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("%0t ERROR: %s", $time, what);
        error_count++;
    endtask

    task automatic drive_box_fields(input box_pair_t p);
        box_if.a_x_min = p.a_x_min;
        box_if.a_y_min = p.a_y_min;
        box_if.a_x_max = p.a_x_max;
        box_if.a_y_max = p.a_y_max;
        box_if.b_x_min = p.b_x_min;
        box_if.b_y_min = p.b_y_min;
        box_if.b_x_max = p.b_x_max;
        box_if.b_y_max = p.b_y_max;
    endtask

    // Offers one box pair, after an optional idle run, and records the ratio it should give
    // once it is accepted. Called and left just after a falling edge. With no idle run the
    // valid stays high, so back-to-back items never lower and raise it in one step.
    task automatic send_box_pair(input box_pair_t p);
        int            gap;
        ratio_expect_t owed;
        gap = src_gap_en ? idle_length() : 0;
        if (gap > 0)
        begin
            box_if.valid = 1'b0;
            repeat (gap)
            begin
                // Junk on the payload while valid is low must not matter.
                drive_box_fields(box_pair_t'({$urandom, $urandom, $urandom, $urandom}));
                @(negedge clk);
            end
        end
        box_if.valid = 1'b1;
        drive_box_fields(p);
        do
            @(posedge clk);
        while (!box_if.ready);
        owed.item_no = items_sent;
        owed.ratio   = predict_overlap_ratio(p, min_union_area_model);
        pending_ratios.push_back(owed);
        items_sent++;
        @(negedge clk);
    endtask

    // Stops offering items and waits until every owed ratio has come out, then lets the
    // pipeline latency pass so the block is idle for a register write.
    task automatic wait_for_results();
        int waited;
        waited       = 0;
        box_if.valid = 1'b0;
        while (pending_ratios.size() != 0 && waited < DRAIN_CYCLES)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (LATENCY + 4) @(negedge clk);
        if (pending_ratios.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived, oldest for item %0d",
                                      pending_ratios.size(), pending_ratios[0].item_no));
            pending_ratios.delete();
        end
    endtask

    task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] data);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        // Only the threshold word holds anything; writes elsewhere are dropped.
        if (addr == ADDR_MIN_UNION_AREA)
            min_union_area_model = data[MUA_W-1:0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] want);
        psel    = 1'b1;
        pwrite  = 1'b0;
        penable = 1'b0;
        paddr   = addr;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
            report_mismatch($sformatf("register at 0x%0h reads 0x%0h, want 0x%0h",
                                      addr, prdata, want));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Threshold changes happen only with the pipeline empty, and are read back.
    task automatic set_min_union_area(input logic [MUA_W-1:0] value);
        wait_for_results();
        write_register(ADDR_MIN_UNION_AREA, APB_DATA_W'(value));
        check_register(ADDR_MIN_UNION_AREA, APB_DATA_W'(min_union_area_model));
    endtask

    // Ratio side: ready drops for random runs while stalls are enabled.
    initial
    begin : ratio_sink
        int stall_left;
        stall_left     = 0;
        ratio_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && sink_stall_en && rand_between(0, 3) == 0)
                stall_left = idle_length();
            if (stall_left > 0)
            begin
                ratio_if.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                ratio_if.ready = 1'b1;
            end
        end
    end

    // Every accepted ratio is matched against the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && ratio_if.valid && ratio_if.ready)
        begin
            if (pending_ratios.size() == 0)
            begin
                report_mismatch($sformatf("result %0d with no item outstanding",
                                          ratio_if.overlap_ratio));
            end
            else
            begin
                oldest_ratio = pending_ratios.pop_front();
                if (ratio_if.overlap_ratio !== oldest_ratio.ratio)
                    report_mismatch($sformatf("item %0d: overlap_ratio %0d, want %0d",
                                              oldest_ratio.item_no, ratio_if.overlap_ratio,
                                              oldest_ratio.ratio));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_reset_value();
        check_register(ADDR_MIN_UNION_AREA, APB_DATA_W'(MUA_RESET));
    endtask

    // Hand-picked pairs at the reset threshold: the edges of the coordinate range, exact
    // matches that saturate to 1.0, empty and touching overlaps, inverted boxes that shrink
    // or flip the union, a union of zero, and unions right around the threshold.
    task automatic test_directed_cases();
        send_box_pair(pair_of(0, 0, 160, 160, 0, 0, 160, 160));
        send_box_pair(pair_of(0, 0, 160, 160, 80, 80, 240, 240));
        send_box_pair(pair_of(0, 0, 320, 320, 16, 16, 48, 48));
        send_box_pair(pair_of(0, 0, 16, 16, 100, 100, 200, 200));
        send_box_pair(pair_of(0, 0, 16, 16, 16, 0, 32, 16));
        send_box_pair(pair_of(0, 0, 16, 16, 16, 16, 32, 32));
        send_box_pair(pair_of(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
        send_box_pair(pair_of(-32768, -32768, 32767, 32767, 0, 0, 1, 1));
        send_box_pair(pair_of(-32768, -32768, 32767, 32767, -32768, -32768, 0, 32767));
        send_box_pair(pair_of(32767, 32767, -32768, -32768, -32768, -32768, 32767, 32767));
        send_box_pair(pair_of(32767, -32768, -32768, 32767, 0, 0, 10, 10));
        send_box_pair(pair_of(100, 0, 0, 100, 0, 0, 10, 10));
        send_box_pair(pair_of(10, 0, 0, 10, 0, 0, 12, 10));
        send_box_pair(pair_of(0, 0, 0, 16, 5, 5, 5, 40));
        send_box_pair(pair_of(0, 0, 1, 1, 0, 0, 1, 1));
        send_box_pair(pair_of(0, 0, 2, 1, 0, 0, 2, 1));
        send_box_pair(pair_of(0, 0, 3, 1, 0, 0, 3, 1));
        send_box_pair(pair_of(0, 0, 2, 1, 1, 0, 3, 1));
        send_box_pair(pair_of(0, 0, 0, 10, 0, 0, 10, 10));
        send_box_pair(pair_of(-1000, -2000, -500, -100, -800, -1500, 200, 300));
        send_box_pair(pair_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_box_pair(pair_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_box_pair(pair_of('hAAAA, 'hAAAA, 'h5555, 'h5555, 'h5555, 'hAAAA, 'hAAAA, 'h5555));
        send_box_pair(pair_of(0, 0, 4096, 4096, 0, 0, 4096, 4095));
    endtask

    // Sweeps the threshold over its extremes and a few values between, each with tiny
    // boxes whose unions straddle it; zero unions with a zero threshold must still give 0.
    task automatic test_threshold_settings();
        logic [MUA_W-1:0] settings[5];
        settings = '{8'd0, 8'd1, 8'd255, 8'd128, MUA_W'(rand_between(2, 254))};
        foreach (settings[s])
        begin
            set_min_union_area(settings[s]);
            send_box_pair(pair_of(0, 0, 0, 16, 0, 0, 16, 0));
            repeat (ITEMS_PER_SETTING) send_box_pair(small_box_pair());
        end
    endtask

    // A write to the empty register word must leave the threshold alone.
    task automatic test_ignored_write();
        set_min_union_area(MUA_RESET);
        write_register(ADDR_UNUSED, '1);
        check_register(ADDR_MIN_UNION_AREA, APB_DATA_W'(min_union_area_model));
        repeat (40) send_box_pair(small_box_pair());
    endtask

    // The bulk of the run: random pairs in phases with different thresholds and idling.
    // The second phase runs at full rate on both sides; the others idle on one side or both.
    task automatic test_random_traffic();
        logic [MUA_W-1:0] phase_thr[RANDOM_PHASES];
        phase_thr = '{MUA_RESET, 8'd0, 8'd255, MUA_W'(rand_between(0, 255))};
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            set_min_union_area(phase_thr[ph]);
            src_gap_en    = (ph == 0 || ph == 3);
            sink_stall_en = (ph == 0 || ph == 2);
            repeat (ITEMS_PER_PHASE) send_box_pair(random_box_pair());
        end
        src_gap_en    = 1'b1;
        sink_stall_en = 1'b1;
    endtask

    initial
    begin : stimulus
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        box_if.valid         = 1'b0;
        drive_box_fields('0);
        src_gap_en           = 1'b1;
        sink_stall_en        = 1'b1;
        items_sent           = 0;
        error_count          = 0;
        min_union_area_model = MUA_RESET;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_reset_value();
        test_directed_cases();
        test_threshold_settings();
        test_ignored_write();
        test_random_traffic();
        wait_for_results();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
sv/biou_pkg.sv
sv/biou_if.sv
sv/biou_front.sv
sv/biou_cell.sv
sv/box_iou.sv
tb/sv/box_iou_tb.sv
